>>> sv/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ADAM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ADAM_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);
`else
`define ADAM_ASSERT(label, prop, msg)
`define ADAM_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

>>> sv/adam_pu_pkg.sv
// types, constants and step functions of the adam parameter update unit
package adam_pu_pkg;

	localparam int SQ_STAGES = 14;
	localparam int DV_STAGES = 17;
	localparam int ROOT_W    = 28;
	localparam int DEN_W     = 29;
	localparam int QUO_W     = 34;
	localparam int RAD_W     = 56;
	localparam int NUMP_W    = 56;

	typedef enum logic [1:0] {
		REG_BETA_ONE  = 2'd0,
		REG_BETA_TWO  = 2'd1,
		REG_EPSILON   = 2'd2,
		REG_STEP_SIZE = 2'd3
	} reg_idx_t;

	localparam logic [15:0] BETA_ONE_RST  = 16'd58982;
	localparam logic [15:0] BETA_TWO_RST  = 16'd65470;
	localparam logic [15:0] EPSILON_RST   = 16'd1;
	localparam logic [31:0] STEP_SIZE_RST = 32'd429497;

	typedef struct packed {
		logic [ROOT_W+3:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_st_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} dv_st_t;

	typedef struct packed {
		logic [31:0] weight;
		logic [31:0] moment;
		logic [31:0] velocity;
		logic [63:0] num;
		logic        sat;
	} sq_side_t;

	typedef struct packed {
		logic [31:0] weight;
		logic [31:0] moment;
		logic [31:0] velocity;
		logic        sat;
	} dv_side_t;

	// one digit of the restoring square root
	function automatic sq_st_t sq_step(sq_st_t s, logic [1:0] pair);
		logic [ROOT_W+3:0] r;
		logic [ROOT_W+3:0] t;
		sq_st_t o;
		r = {s.rem[ROOT_W+1:0], pair};
		t = {2'b00, s.root, 2'b01};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// one bit of the restoring division
	function automatic dv_st_t dv_step(dv_st_t s, logic [DEN_W-1:0] den, logic nb);
		logic [DEN_W:0] r;
		logic [DEN_W:0] d;
		dv_st_t o;
		r = {s.rem, nb};
		d = {1'b0, den};
		if (r >= d) begin
			o.rem = DEN_W'(r - d);
			o.quo = {s.quo[QUO_W-2:0], 1'b1};
		end else begin
			o.rem = r[DEN_W-1:0];
			o.quo = {s.quo[QUO_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

>>> sv/adam_pu_sqrt.sv
// pipelined square root, two result bits per stage
module adam_pu_sqrt (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_vld,
	input  logic [31:0]                          in_rad,
	input  adam_pu_pkg::sq_side_t                in_side,
	output logic                                 out_vld,
	output logic [adam_pu_pkg::ROOT_W-1:0]       out_root,
	output adam_pu_pkg::sq_side_t                out_side
);

	logic                               vld_s  [1:adam_pu_pkg::SQ_STAGES];
	adam_pu_pkg::sq_st_t                st_s   [1:adam_pu_pkg::SQ_STAGES];
	logic [adam_pu_pkg::RAD_W-1:0]      rad_s  [1:adam_pu_pkg::SQ_STAGES];
	adam_pu_pkg::sq_side_t              side_s [1:adam_pu_pkg::SQ_STAGES];

	for (genvar k = 1; k <= adam_pu_pkg::SQ_STAGES; k++) begin : g_stg
		logic                          pv;
		adam_pu_pkg::sq_st_t           pst;
		logic [adam_pu_pkg::RAD_W-1:0] prad;
		adam_pu_pkg::sq_side_t         pside;
		adam_pu_pkg::sq_st_t           mid;
		adam_pu_pkg::sq_st_t           nxt;

		if (k == 1) begin : g_first
			assign pv    = in_vld;
			assign pst   = '0;
			assign prad  = {in_rad, {(adam_pu_pkg::RAD_W-32){1'b0}}};
			assign pside = in_side;
		end else begin : g_rest
			assign pv    = vld_s[k-1];
			assign pst   = st_s[k-1];
			assign prad  = rad_s[k-1];
			assign pside = side_s[k-1];
		end

		always_comb begin
			mid = adam_pu_pkg::sq_step(pst, prad[adam_pu_pkg::RAD_W-1 -: 2]);
			nxt = adam_pu_pkg::sq_step(mid, prad[adam_pu_pkg::RAD_W-3 -: 2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k]   <= nxt;
				rad_s[k]  <= {prad[adam_pu_pkg::RAD_W-5:0], 4'b0000};
				side_s[k] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[adam_pu_pkg::SQ_STAGES];
	assign out_root = st_s[adam_pu_pkg::SQ_STAGES].root;
	assign out_side = side_s[adam_pu_pkg::SQ_STAGES];

endmodule

>>> sv/adam_pu_div.sv
// pipelined divider of the pre-rounded numerator for the weight step, two quotient bits per stage
module adam_pu_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_vld,
	input  logic [adam_pu_pkg::DEN_W-1:0]        in_den,
	input  logic [adam_pu_pkg::NUMP_W-1:0]       in_np,
	input  adam_pu_pkg::dv_side_t                in_side,
	output logic                                 out_vld,
	output logic [adam_pu_pkg::QUO_W-1:0]        out_quo,
	output adam_pu_pkg::dv_side_t                out_side
);

	localparam int HI_W = adam_pu_pkg::NUMP_W - adam_pu_pkg::QUO_W;

	logic                               vld_s  [1:adam_pu_pkg::DV_STAGES];
	adam_pu_pkg::dv_st_t                st_s   [1:adam_pu_pkg::DV_STAGES];
	logic [adam_pu_pkg::QUO_W-1:0]      bits_s [1:adam_pu_pkg::DV_STAGES];
	logic [adam_pu_pkg::DEN_W-1:0]      den_s  [1:adam_pu_pkg::DV_STAGES];
	logic                               big_s  [1:adam_pu_pkg::DV_STAGES];
	adam_pu_pkg::dv_side_t              side_s [1:adam_pu_pkg::DV_STAGES];

	logic [adam_pu_pkg::DEN_W-1:0] hi_part;
	logic                          in_big;

	// quotient of 2^34 or more always clips the weight
	assign hi_part = {{(adam_pu_pkg::DEN_W-HI_W){1'b0}},
		in_np[adam_pu_pkg::NUMP_W-1:adam_pu_pkg::QUO_W]};
	assign in_big  = hi_part >= in_den;

	for (genvar k = 1; k <= adam_pu_pkg::DV_STAGES; k++) begin : g_stg
		logic                          pv;
		adam_pu_pkg::dv_st_t           pst;
		logic [adam_pu_pkg::QUO_W-1:0] pbits;
		logic [adam_pu_pkg::DEN_W-1:0] pden;
		logic                          pbig;
		adam_pu_pkg::dv_side_t         pside;
		adam_pu_pkg::dv_st_t           mid;
		adam_pu_pkg::dv_st_t           nxt;

		if (k == 1) begin : g_first
			assign pv    = in_vld;
			assign pst   = '{rem: hi_part, quo: '0};
			assign pbits = in_np[adam_pu_pkg::QUO_W-1:0];
			assign pden  = in_den;
			assign pbig  = in_big;
			assign pside = in_side;
		end else begin : g_rest
			assign pv    = vld_s[k-1];
			assign pst   = st_s[k-1];
			assign pbits = bits_s[k-1];
			assign pden  = den_s[k-1];
			assign pbig  = big_s[k-1];
			assign pside = side_s[k-1];
		end

		always_comb begin
			mid = adam_pu_pkg::dv_step(pst, pden, pbits[adam_pu_pkg::QUO_W-1]);
			nxt = adam_pu_pkg::dv_step(mid, pden, pbits[adam_pu_pkg::QUO_W-2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k]   <= nxt;
				bits_s[k] <= {pbits[adam_pu_pkg::QUO_W-3:0], 2'b00};
				den_s[k]  <= pden;
				big_s[k]  <= pbig;
				side_s[k] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[adam_pu_pkg::DV_STAGES];
	assign out_quo  = big_s[adam_pu_pkg::DV_STAGES] ? '1 : st_s[adam_pu_pkg::DV_STAGES].quo;
	assign out_side = side_s[adam_pu_pkg::DV_STAGES];

endmodule

>>> sv/adam_parameter_update_unit.sv
// top level of the adam parameter update unit
//
//  channel   handshake                     payload
//  item      item_valid / item_ready       weight_in moment_in velocity_in gradient_in
//  result    result_valid / result_ready   weight_out moment_out velocity_out saturated
//  config    apb psel penable pwrite       paddr pwdata prdata pready
//
// one transaction per cycle while no result waits; 4 arithmetic stages, 14 square
// root stages, 1 denominator stage, 17 divider stages, 1 output stage
// the whole pipeline holds while a result waits, so item_ready follows result_ready
// reset clears the valid bits and loads the register defaults
module adam_parameter_update_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic signed [31:0] weight_in,
	input  logic signed [31:0] moment_in,
	input  logic [31:0]        velocity_in,
	input  logic signed [31:0] gradient_in,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] weight_out,
	output logic signed [31:0] moment_out,
	output logic [31:0]        velocity_out,
	output logic               saturated
);

`include "assert_macros.svh"

	logic [15:0] beta_one_q;
	logic [15:0] beta_two_q;
	logic [15:0] epsilon_q;
	logic [31:0] step_size_q;

	adam_pu_pkg::reg_idx_t cfg_idx;
	logic                  cfg_wr;
	logic                  adv;

	assign cfg_idx = adam_pu_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_one_q  <= adam_pu_pkg::BETA_ONE_RST;
			beta_two_q  <= adam_pu_pkg::BETA_TWO_RST;
			epsilon_q   <= adam_pu_pkg::EPSILON_RST;
			step_size_q <= adam_pu_pkg::STEP_SIZE_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				adam_pu_pkg::REG_BETA_ONE:  beta_one_q  <= pwdata[15:0];
				adam_pu_pkg::REG_BETA_TWO:  beta_two_q  <= pwdata[15:0];
				adam_pu_pkg::REG_EPSILON:   epsilon_q   <= pwdata[15:0];
				adam_pu_pkg::REG_STEP_SIZE: step_size_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			adam_pu_pkg::REG_BETA_ONE:  prdata = {16'h0000, beta_one_q};
			adam_pu_pkg::REG_BETA_TWO:  prdata = {16'h0000, beta_two_q};
			adam_pu_pkg::REG_EPSILON:   prdata = {16'h0000, epsilon_q};
			adam_pu_pkg::REG_STEP_SIZE: prdata = step_size_q;
			default:                    prdata = '0;
		endcase
	end

	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	// stage 1: products
	logic                vld_s1;
	logic signed [49:0]  pm1_s1;
	logic signed [49:0]  pm2_s1;
	logic [63:0]         gsq_s1;
	logic [47:0]         pv1_s1;
	logic signed [31:0]  w_s1;
	logic [16:0]         c1;
	logic [31:0]         gmag;

	assign c1   = 17'h10000 - {1'b0, beta_one_q};
	assign gmag = gradient_in[31] ? 32'(-gradient_in) : 32'(gradient_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pm1_s1 <= $signed({1'b0, beta_one_q}) * moment_in;
			pm2_s1 <= $signed({1'b0, c1}) * gradient_in;
			gsq_s1 <= 64'(gmag) * 64'(gmag);
			pv1_s1 <= 48'(beta_two_q) * 48'(velocity_in);
			w_s1   <= weight_in;
		end
	end

	// stage 2: moment rounding and clipping, squared gradient rounding
	logic                vld_s2;
	logic signed [31:0]  mn_s2;
	logic                sat_s2;
	logic [38:0]         g2_s2;
	logic [47:0]         pv1_s2;
	logic signed [31:0]  w_s2;
	logic signed [50:0]  macc;
	logic [50:0]         mmag;
	logic [34:0]         mrnd;
	logic signed [35:0]  msgn;
	logic signed [31:0]  mclip;
	logic                msat;

	always_comb begin
		macc = 51'(pm1_s1) + 51'(pm2_s1);
		mmag = macc[50] ? 51'(-macc) : 51'(macc);
		mrnd = 35'((mmag + 51'd32768) >> 16);
		msgn = macc[50] ? -$signed({1'b0, mrnd}) : $signed({1'b0, mrnd});
		msat = 1'b0;
		mclip = msgn[31:0];
		if (msgn > 36'sd2147483647) begin
			mclip = 32'h7fffffff;
			msat  = 1'b1;
		end else if (msgn < -36'sd2147483648) begin
			mclip = 32'h80000000;
			msat  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mn_s2  <= mclip;
			sat_s2 <= msat;
			g2_s2  <= 39'((gsq_s1 + 64'd8388608) >> 24);
			pv1_s2 <= pv1_s1;
			w_s2   <= w_s1;
		end
	end

	// stage 3: velocity gradient product, step numerator
	logic                vld_s3;
	logic [55:0]         pv2_s3;
	logic [47:0]         pv1_s3;
	logic [63:0]         num_s3;
	logic signed [31:0]  mn_s3;
	logic                sat_s3;
	logic signed [31:0]  w_s3;
	logic [16:0]         c2;
	logic [31:0]         mabs;

	assign c2   = 17'h10000 - {1'b0, beta_two_q};
	assign mabs = mn_s2[31] ? 32'(-mn_s2) : 32'(mn_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pv2_s3 <= 56'(c2) * 56'(g2_s2);
			pv1_s3 <= pv1_s2;
			num_s3 <= 64'(step_size_q) * 64'(mabs);
			mn_s3  <= mn_s2;
			sat_s3 <= sat_s2;
			w_s3   <= w_s2;
		end
	end

	// stage 4: velocity sum, rounding and clipping
	logic                  vld_s4;
	adam_pu_pkg::sq_side_t side_s4;
	logic [56:0]           vacc;
	logic [40:0]           vrnd;
	logic                  vsat;

	always_comb begin
		vacc = 57'(pv1_s3) + 57'(pv2_s3);
		vrnd = 41'((vacc + 57'd32768) >> 16);
		vsat = |vrnd[40:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.weight   <= w_s3;
			side_s4.moment   <= mn_s3;
			side_s4.velocity <= vsat ? 32'hffffffff : vrnd[31:0];
			side_s4.num      <= num_s3;
			side_s4.sat      <= sat_s3 | vsat;
		end
	end

	logic                                sq_vld;
	logic [adam_pu_pkg::ROOT_W-1:0]      sq_root;
	adam_pu_pkg::sq_side_t               sq_side;

	adam_pu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s4),
		.in_rad   (side_s4.velocity),
		.in_side  (side_s4),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// stage 5: denominator and rounded numerator
	logic                              vld_s5;
	logic [adam_pu_pkg::DEN_W-1:0]     den_s5;
	logic [adam_pu_pkg::NUMP_W-1:0]    np_s5;
	adam_pu_pkg::dv_side_t             dside_s5;
	logic [adam_pu_pkg::DEN_W-1:0]     den_raw;
	logic [adam_pu_pkg::DEN_W-1:0]     den_fix;
	logic [63:0]                       nsum;

	always_comb begin
		den_raw = {1'b0, sq_root} + adam_pu_pkg::DEN_W'(epsilon_q);
		den_fix = (den_raw == '0) ? adam_pu_pkg::DEN_W'(1) : den_raw;
		nsum    = sq_side.num + 64'({den_fix, 7'b0000000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s5            <= den_fix;
			np_s5             <= nsum[63:8];
			dside_s5.weight   <= sq_side.weight;
			dside_s5.moment   <= sq_side.moment;
			dside_s5.velocity <= sq_side.velocity;
			dside_s5.sat      <= sq_side.sat;
		end
	end

	logic                              dv_vld;
	logic [adam_pu_pkg::QUO_W-1:0]     dv_quo;
	adam_pu_pkg::dv_side_t             dv_side;

	adam_pu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s5),
		.in_den   (den_s5),
		.in_np    (np_s5),
		.in_side  (dside_s5),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// stage 6: weight update and output register
	logic                vld_s6;
	logic signed [31:0]  w_s6;
	logic signed [31:0]  mn_s6;
	logic [31:0]         v_s6;
	logic                sat_s6;
	logic signed [35:0]  wsum;
	logic signed [31:0]  wclip;
	logic                wsat;

	always_comb begin
		if (dv_side.moment[31]) begin
			wsum = 36'($signed(dv_side.weight)) - $signed({2'b00, dv_quo});
		end else begin
			wsum = 36'($signed(dv_side.weight)) + $signed({2'b00, dv_quo});
		end
		wsat  = 1'b0;
		wclip = wsum[31:0];
		if (wsum > 36'sd2147483647) begin
			wclip = 32'h7fffffff;
			wsat  = 1'b1;
		end else if (wsum < -36'sd2147483648) begin
			wclip = 32'h80000000;
			wsat  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s6   <= wclip;
			mn_s6  <= dv_side.moment;
			v_s6   <= dv_side.velocity;
			sat_s6 <= dv_side.sat | wsat;
		end
	end

	assign result_valid = vld_s6;
	assign weight_out   = w_s6;
	assign moment_out   = mn_s6;
	assign velocity_out = v_s6;
	assign saturated    = sat_s6;

	`ADAM_ASSERT_NEXT(a_entry, adv, (vld_s1 == $past(item_valid)), "transaction lost at entry")
	`ADAM_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_s4), "pipeline moved during a stall")
	`ADAM_ASSERT_NEXT(a_cfg_step, (cfg_wr && (cfg_idx == adam_pu_pkg::REG_STEP_SIZE)), (step_size_q == $past(pwdata)), "step size write lost")

endmodule
